>>> hw/rtl/jeo_pkg.sv
// Shared constants for the ring elimination order block.
// No dependencies; imported by every module of the block.
`default_nettype none

package jeo_pkg;

	localparam int MAX_PEOPLE_DEF = 64;
	localparam int STEP_WIDTH_DEF = 16;

	// fixed field widths
	localparam int COUNT_W    = 7;
	localparam int STEP_CFG_W = 16;
	localparam int PERSON_W   = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PEOPLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_PERSON = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/jeo_mod.sv
// Iterative remainder unit, one quotient bit per cycle (restoring).
// Depends on jeo_pkg. Used by josephus_elimination_order for the skip count.
`default_nettype none

module jeo_mod
	import jeo_pkg::*;
#(
	parameter int DIVIDEND_W = STEP_WIDTH_DEF,
	parameter int DIVISOR_W  = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic      [DIVISOR_W-1:0]  rem,
	output logic                       done
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] bits_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;
	logic [DIVISOR_W-1:0]  rem_nxt;

	// partial remainder stays below the divisor, so trial fits one extra bit
	assign trial   = {rem_q, bits_q[DIVIDEND_W-1]};
	assign ge      = trial >= {1'b0, divisor};
	assign diff    = trial - {1'b0, divisor};
	assign rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			bits_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= rem_nxt;
			bits_q <= bits_q << 1;
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

`default_nettype wire

>>> hw/rtl/josephus_elimination_order.sv
// Channel   | Dir | Word contents (low bit up)
// s_axis    | in  | tdata: direction[0], zeros[7:1]
// m_axis    | out | tdata: person[6:0], zero[7]; tlast: last; tuser: error
// cfg       | in  | cfg_index selects people_count / step_length / start_person
//
// One run per input word. A run builds the ring, then for each of the n-1
// eliminations runs the remainder unit and then walks the links, where
// moves = (step-1) mod remaining; each link hop is one registered read of the
// link memory. A bad start yields a single error word.
// Reset clears control only; link memories need no clearing pass.
// A stalled m_axis holds the run; s_axis is taken only between runs.
// Depends on jeo_pkg and jeo_mod.
`default_nettype none

module josephus_elimination_order
	import jeo_pkg::*;
#(
	parameter int MAX_PEOPLE = MAX_PEOPLE_DEF,
	parameter int STEP_WIDTH = STEP_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,   // [0] direction, [7:1] zero
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [7:0]                 m_axis_tdata,   // [6:0] person, [7] zero
	output logic                       m_axis_tlast,   // last
	output logic                       m_axis_tuser,   // [0] error
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_PEOPLE);
	localparam int CW = $clog2(MAX_PEOPLE + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_ERR, ST_BUILD, ST_DIV_GO, ST_DIV_WAIT, ST_WALK_A, ST_WALK_B, ST_FINAL
	} state_t;

	state_t state_q;

	logic [COUNT_W-1:0]    people_q;
	logic [STEP_CFG_W-1:0] step_q;
	logic [COUNT_W-1:0]    start_q;

	logic          dir_q;
	logic [IW-1:0] n_last_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] cur_q;
	logic [CW-1:0] remaining_q;
	logic [CW-1:0] moves_q;
	logic          div_go_q;

	logic [PERSON_W-1:0] out_person_q;
	logic                out_last_q;
	logic                out_error_q;
	logic                out_valid_q;

	// link memories
	logic [IW-1:0] next_mem [MAX_PEOPLE];
	logic [IW-1:0] prev_mem [MAX_PEOPLE];
	logic [IW-1:0] next_rd_s1;
	logic [IW-1:0] prev_rd_s1;

	logic          mem_we;
	logic [IW-1:0] n_waddr, n_wdata, p_waddr, p_wdata;

	logic          bad_start;
	logic          out_free;
	logic          unlink;
	logic [CW-1:0] rem_dec;
	logic [IW-1:0] walk_nxt;

	logic [STEP_WIDTH+STEP_CFG_W-1:0] step_ext;
	logic [STEP_WIDTH-1:0]            dividend;
	logic [CW-1:0]                    div_rem;
	logic                             div_done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			people_q <= COUNT_W'(1);
			step_q   <= STEP_CFG_W'(1);
			start_q  <= COUNT_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PEOPLE_COUNT: people_q <= cfg_data[COUNT_W-1:0];
				REG_STEP_LENGTH:  step_q   <= cfg_data[STEP_CFG_W-1:0];
				REG_START_PERSON: start_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign bad_start = (people_q == '0) || (people_q > COUNT_W'(MAX_PEOPLE))
		|| (start_q == '0) || (start_q > people_q);

	// skip count is (step-1) mod remaining; a zero step wraps to 2^STEP_WIDTH
	assign step_ext = {{STEP_WIDTH{1'b0}}, step_q};
	assign dividend = step_ext[STEP_WIDTH-1:0] - STEP_WIDTH'(1);

	jeo_mod #(
		.DIVIDEND_W (STEP_WIDTH),
		.DIVISOR_W  (CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (dividend),
		.divisor  (remaining_q),
		.rem      (div_rem),
		.done     (div_done)
	);

	assign out_free = !out_valid_q || m_axis_tready;
	assign unlink   = (state_q == ST_WALK_B) && (moves_q == '0) && out_free;
	assign rem_dec  = remaining_q - 1'b1;
	assign walk_nxt = dir_q ? prev_rd_s1 : next_rd_s1;

	always_comb begin
		mem_we  = 1'b0;
		n_waddr = idx_q;
		p_waddr = idx_q;
		n_wdata = (idx_q == n_last_q) ? '0 : idx_q + 1'b1;
		p_wdata = (idx_q == '0) ? n_last_q : idx_q - 1'b1;
		if (state_q == ST_BUILD) begin
			mem_we = 1'b1;
		end else if (unlink) begin
			mem_we  = 1'b1;
			n_waddr = prev_rd_s1;
			n_wdata = next_rd_s1;
			p_waddr = next_rd_s1;
			p_wdata = prev_rd_s1;
		end
	end

	// the FSM never uses a read taken in the cycle of a write, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (mem_we) begin
			next_mem[n_waddr] <= n_wdata;
			prev_mem[p_waddr] <= p_wdata;
		end
		next_rd_s1 <= next_mem[cur_q];
		prev_rd_s1 <= prev_mem[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dir_q        <= 1'b0;
			n_last_q     <= '0;
			idx_q        <= '0;
			cur_q        <= '0;
			remaining_q  <= '0;
			moves_q      <= '0;
			div_go_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_person_q <= '0;
			out_last_q   <= 1'b0;
			out_error_q  <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						dir_q    <= s_axis_tdata[0];
						idx_q    <= '0;
						n_last_q <= IW'(people_q - 1'b1);
						state_q  <= bad_start ? ST_ERR : ST_BUILD;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_person_q <= '0;
						out_last_q   <= 1'b1;
						out_error_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_BUILD: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == n_last_q) begin
						cur_q       <= IW'(start_q - 1'b1);
						remaining_q <= CW'(people_q);
						state_q     <= (n_last_q == '0) ? ST_FINAL : ST_DIV_GO;
						div_go_q    <= (n_last_q != '0);
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						moves_q <= div_rem;
						state_q <= ST_WALK_A;
					end
				end
				ST_WALK_A: begin
					// links of cur_q land in the read registers at this edge
					state_q <= ST_WALK_B;
				end
				ST_WALK_B: begin
					if (moves_q != '0) begin
						cur_q   <= walk_nxt;
						moves_q <= moves_q - 1'b1;
						state_q <= ST_WALK_A;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_person_q <= PERSON_W'(cur_q) + 1'b1;
						out_last_q   <= 1'b0;
						out_error_q  <= 1'b0;
						cur_q        <= walk_nxt;
						remaining_q  <= rem_dec;
						if (rem_dec == CW'(1)) begin
							state_q <= ST_FINAL;
						end else begin
							state_q  <= ST_DIV_GO;
							div_go_q <= 1'b1;
						end
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_person_q <= PERSON_W'(cur_q) + 1'b1;
						out_last_q   <= 1'b1;
						out_error_q  <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_person_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_error_q;

endmodule

`default_nettype wire

>>> hw/rtl/jeo_checker.sv
// Port-level checks for josephus_elimination_order, bound to the top level.
// Depends on jeo_pkg.
`default_nettype none

module jeo_checker
	import jeo_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast,
	input wire logic       m_axis_tuser
);

	// error word carries person zero and closes the run
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[PERSON_W-1:0] == '0 && m_axis_tlast)
		else $error("error word malformed");

	// a real person is numbered from one
	a_person_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[PERSON_W-1:0] != '0)
		else $error("person zero on a normal word");

	// only one run in flight
	a_one_run: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken during a run");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled output word changed");

endmodule

bind josephus_elimination_order jeo_checker u_jeo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
